// ===== hdl/assert_macros.svh =====
// assertion macros shared by the semaphore core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PWS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication
`define PWS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PWS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PWS_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== hdl/pws_pkg.sv =====
// types and constants of the priority wait semaphore core
`timescale 1ns / 1ps
package pws_pkg;

    localparam int SEM_W   = 2;
    localparam int PID_W   = 4;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 6;
    localparam int CFG_W   = 4;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 6'sd31;

    // request kinds
    localparam logic ACT_P = 1'b0;
    localparam logic ACT_V = 1'b1;

    typedef struct packed {
        logic [PID_W-1:0]  id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // best-so-far word handed along the cell row
    typedef struct packed {
        logic   valid;
        entry_t ent;
    } tok_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic [SEM_W-1:0] sem;
        logic             in_use;
        logic             append;
        logic             shift;
        entry_t           new_ent;
    } cell_ctl_t;

endpackage

// ===== hdl/pws_cell.sv =====
// one wait-queue slot for every semaphore, with its stage of the priority scan
`timescale 1ns / 1ps
module pws_cell
    import pws_pkg::*;
#(
    parameter int NUM_SEMS  = 4,
    parameter int SEM_IDX_W = 2,
    parameter int BIDX_W    = 3,
    parameter int CELL_IDX  = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  entry_t            nbr_ent,
    input  tok_t              tok_in,
    input  logic [BIDX_W-1:0] tok_in_idx,
    output entry_t            own_ent,
    output tok_t              tok_out,
    output logic [BIDX_W-1:0] tok_out_idx
);

    entry_t               ent_reg [NUM_SEMS];
    logic [SEM_IDX_W-1:0] sel;
    logic                 take;
    tok_t                 tok_reg;
    tok_t                 tok_next;
    logic [BIDX_W-1:0]    idx_reg;
    logic [BIDX_W-1:0]    idx_next;

    assign sel     = SEM_IDX_W'(ctl.sem);
    assign own_ent = ent_reg[sel];

    always_ff @(posedge clk)
    begin
        if (ctl.append)
        begin
            ent_reg[sel] <= ctl.new_ent;
        end
        else if (ctl.shift)
        begin
            ent_reg[sel] <= nbr_ent;
        end
    end

    // strict compare keeps the earlier waiter on a tie
    always_comb
    begin
        take = ctl.in_use && (!tok_in.valid || (own_ent.prio > tok_in.ent.prio));
        if (take)
        begin
            tok_next = '{valid: 1'b1, ent: own_ent};
            idx_next = BIDX_W'(CELL_IDX);
        end
        else
        begin
            tok_next = tok_in;
            idx_next = tok_in_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign tok_out     = tok_reg;
    assign tok_out_idx = idx_reg;

endmodule

// ===== hdl/priority_wait_semaphore_core.sv =====
// bank of counting semaphores with priority-ordered wait queues
//
// channel  | dir | handshake         | contents
// ---------+-----+-------------------+--------------------------------------------
// request  | in  | s_tvalid/s_tready | s_tuser: action; s_tdata: sem, proc, priority
// result   | out | m_tvalid/m_tready | m_tdata: blocked, woken, proc, count, error
// config   | in  | cfg_wr_en         | cfg_index selects init count, cfg_data value
//
// a P, a V on an empty queue, or a request to an unknown semaphore is accepted, then committed
// a V with waiters is accepted, then scanned, then committed; the best-priority word walks
//   the cell row one slot per cycle before the commit
// reset loads every count with 1; queue slots hold no reset value
// commit waits while a finished word sits unread on the result side
// a config write reloads that count and so empties its queue
`timescale 1ns / 1ps
`include "assert_macros.svh"
module priority_wait_semaphore_core
    import pws_pkg::*;
#(
    parameter int NUM_SEMS    = 4,
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // request words
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [0:0]       s_tuser,   // [0] action
    input  logic [15:0]      s_tdata,   // [1:0] sem_id, [5:2] proc_id, [13:6] proc_priority
    // result words
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [0] caller_blocked, [1] woken_valid,
                                        // [5:2] woken_proc, [11:6] new_count,
                                        // [12] queue_full_error
    // register writes
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int QIDX_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int BIDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SEM_IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // semaphore counts
    logic signed [COUNT_W-1:0] sem_count_reg [NUM_SEMS];

    // latched request
    logic                      act_reg;
    logic [SEM_W-1:0]          sem_reg;
    entry_t                    req_reg;
    logic                      sem_ok_reg;
    logic signed [COUNT_W-1:0] cnt_reg;
    logic [QIDX_W-1:0]         len_reg;
    logic [BIDX_W-1:0]         scan_reg;

    // incoming fields
    logic                      in_act;
    logic [SEM_W-1:0]          in_sem;
    entry_t                    in_ent;
    logic                      in_ok;
    logic signed [COUNT_W-1:0] in_cnt;
    logic [QIDX_W-1:0]         in_len;
    logic                      accept;

    // result register
    logic                      out_valid_reg;
    logic                      out_blocked_reg;
    logic                      out_wvalid_reg;
    logic [PID_W-1:0]          out_proc_reg;
    logic signed [COUNT_W-1:0] out_count_reg;
    logic                      out_err_reg;

    // commit decisions
    logic                      slot_free;
    logic                      commit_go;
    logic                      c_blocked;
    logic                      c_wvalid;
    logic [PID_W-1:0]          c_proc;
    logic signed [COUNT_W-1:0] c_count;
    logic                      c_err;
    logic                      c_append;
    logic                      c_shift;

    // cell row
    cell_ctl_t         cell_ctl [QUEUE_DEPTH];
    entry_t            own_ent  [QUEUE_DEPTH];
    entry_t            nbr_ent  [QUEUE_DEPTH];
    tok_t              tok_in   [QUEUE_DEPTH];
    tok_t              tok_out  [QUEUE_DEPTH];
    logic [BIDX_W-1:0] idx_in   [QUEUE_DEPTH];
    logic [BIDX_W-1:0] idx_out  [QUEUE_DEPTH];
    tok_t              best_tok;
    logic [BIDX_W-1:0] best_idx;

    // ---------------------------------------------------------------- input side
    assign in_act      = s_tuser[0];
    assign in_sem      = s_tdata[1:0];
    assign in_ent.id   = s_tdata[5:2];
    assign in_ent.prio = s_tdata[13:6];
    assign in_ok       = int'(in_sem) < NUM_SEMS;
    assign in_cnt      = in_ok ? sem_count_reg[SEM_IDX_W'(in_sem)] : '0;
    // a count of -n means n waiters
    assign in_len      = in_cnt[COUNT_W-1] ? QIDX_W'(-in_cnt) : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ok && (in_act == ACT_V) && (in_len != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                // last cell holds the winner once the scan has passed every slot
                if (scan_reg == BIDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                scan_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= in_act;
            sem_reg    <= in_sem;
            req_reg    <= in_ent;
            sem_ok_reg <= in_ok;
            cnt_reg    <= in_cnt;
            len_reg    <= in_len;
        end
    end

    // ---------------------------------------------------------------- commit
    assign slot_free = !out_valid_reg || m_tready;
    assign commit_go = (state_reg == ST_COMMIT) && slot_free;
    assign best_tok  = tok_out[QUEUE_DEPTH-1];
    assign best_idx  = idx_out[QUEUE_DEPTH-1];

    always_comb
    begin
        c_blocked = 1'b0;
        c_wvalid  = 1'b0;
        c_proc    = '0;
        c_count   = '0;
        c_err     = 1'b0;
        c_append  = 1'b0;
        c_shift   = 1'b0;
        if (sem_ok_reg)
        begin
            c_count = cnt_reg;
            if (act_reg == ACT_P)
            begin
                if (len_reg == QIDX_W'(QUEUE_DEPTH))
                begin
                    // full queue: nothing changes
                    c_err = 1'b1;
                end
                else
                begin
                    c_count = cnt_reg - 6'sd1;
                    if (cnt_reg[COUNT_W-1] || (cnt_reg == '0))
                    begin
                        c_blocked = 1'b1;
                        c_append  = 1'b1;
                    end
                end
            end
            else
            begin
                if (len_reg != '0)
                begin
                    c_wvalid = 1'b1;
                    c_proc   = best_tok.ent.id;
                    c_shift  = 1'b1;
                    c_count  = cnt_reg + 6'sd1;
                end
                else if (cnt_reg != COUNT_MAX)
                begin
                    c_count = cnt_reg + 6'sd1;
                end
            end
        end
    end

    // counts: reset and config reload, commit update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SEMS; s++)
            begin
                sem_count_reg[s] <= 6'sd1;
            end
        end
        else
        begin
            if (cfg_wr_en && (int'(cfg_index) < NUM_SEMS))
            begin
                sem_count_reg[SEM_IDX_W'(cfg_index)] <= {2'b00, cfg_data};
            end
            else if (commit_go && sem_ok_reg)
            begin
                sem_count_reg[SEM_IDX_W'(sem_reg)] <= c_count;
            end
        end
    end

    // ---------------------------------------------------------------- cell row
    generate
        for (genvar k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            assign cell_ctl[k].sem     = sem_reg;
            assign cell_ctl[k].in_use  = QIDX_W'(k) < len_reg;
            assign cell_ctl[k].append  = commit_go && c_append && (len_reg == QIDX_W'(k));
            // close the gap behind the removed waiter
            assign cell_ctl[k].shift   = commit_go && c_shift && (best_idx <= BIDX_W'(k))
                                         && (QIDX_W'(k + 1) < len_reg);
            assign cell_ctl[k].new_ent = req_reg;

            if (k == 0)
            begin : g_head
                assign tok_in[k] = '0;
                assign idx_in[k] = '0;
            end
            else
            begin : g_link
                assign tok_in[k] = tok_out[k-1];
                assign idx_in[k] = idx_out[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nbr_ent[k] = '0;
            end
            else
            begin : g_next
                assign nbr_ent[k] = own_ent[k+1];
            end

            pws_cell #(
                .NUM_SEMS  (NUM_SEMS),
                .SEM_IDX_W (SEM_IDX_W),
                .BIDX_W    (BIDX_W),
                .CELL_IDX  (k)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (cell_ctl[k]),
                .nbr_ent     (nbr_ent[k]),
                .tok_in      (tok_in[k]),
                .tok_in_idx  (idx_in[k]),
                .own_ent     (own_ent[k]),
                .tok_out     (tok_out[k]),
                .tok_out_idx (idx_out[k])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_go)
        begin
            out_blocked_reg <= c_blocked;
            out_wvalid_reg  <= c_wvalid;
            out_proc_reg    <= c_proc;
            out_count_reg   <= c_count;
            out_err_reg     <= c_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_err_reg, out_count_reg, out_proc_reg,
                       out_wvalid_reg, out_blocked_reg};

    // ---------------------------------------------------------------- checks
    `PWS_ASSERT_NXT(a_commit_shows, clk, rst_n, commit_go, m_tvalid)
    `PWS_ASSERT_IMP(a_wake_alone, clk, rst_n, m_tvalid && out_wvalid_reg, !out_blocked_reg && !out_err_reg)
    `PWS_ASSERT_IMP(a_len_bound, clk, rst_n, state_reg != ST_IDLE, len_reg <= QIDX_W'(QUEUE_DEPTH))
    `PWS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule
